FILE: rtl/core/barycentric_normal_interpolator_unit_defines.svh
// Assertion helpers shared by the interpolator RTL
`ifndef BARYCENTRIC_NORMAL_INTERPOLATOR_UNIT_DEFINES_SVH
`define BARYCENTRIC_NORMAL_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset
`define BNI_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define BNI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bni_pkg.sv
`timescale 1ns / 1ps
package bni_pkg;
    localparam int NORMAL_W = 16;
    localparam int WEIGHT_W = 15;
    localparam int UNIT_W   = 16;
    localparam int LANES    = 3;
endpackage

FILE: rtl/core/bni_sum_lane.sv
`timescale 1ns / 1ps
module bni_sum_lane #(
    parameter int F  = 14,
    parameter int WB = 15,
    parameter int MW = 20
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [bni_pkg::NORMAL_W-1:0] n0,
    input  logic signed [bni_pkg::NORMAL_W-1:0] n1,
    input  logic signed [bni_pkg::NORMAL_W-1:0] n2,
    input  logic        [bni_pkg::WEIGHT_W-1:0] u,
    input  logic        [bni_pkg::WEIGHT_W-1:0] v,
    output logic        [MW-1:0]                mag_o,
    output logic                                neg_o
);
    localparam int PW   = bni_pkg::NORMAL_W + WB + 1;
    localparam int SUMW = PW + 2;

    logic [WB+1:0] one_ext;
    logic [WB+1:0] w_full;
    logic [WB-1:0] w_sat;
    logic [WB-1:0] u_ext;
    logic [WB-1:0] v_ext;

    logic signed [bni_pkg::NORMAL_W-1:0] n0_reg, n1_reg, n2_reg;
    logic [WB-1:0] u_reg, v_reg, w_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [PW-1:0] p0_next, p1_next, p2_next;

    logic signed [SUMW-1:0] sum;
    logic [SUMW-1:0] mag;
    logic [SUMW:0]   rnd;

    // Form the third weight, saturated at zero
    always_comb begin
        u_ext   = WB'(u);
        v_ext   = WB'(v);
        one_ext = (WB+2)'(1) << F;
        w_full  = one_ext - {2'b00, u_ext} - {2'b00, v_ext};
        w_sat   = w_full[WB+1] ? '0 : w_full[WB-1:0];
    end

    // Weight each vertex normal
    always_comb begin
        p0_next = PW'(n0_reg * $signed({1'b0, u_reg}));
        p1_next = PW'(n1_reg * $signed({1'b0, v_reg}));
        p2_next = PW'(n2_reg * $signed({1'b0, w_reg}));
    end

    // Sum exactly, round halves away from zero
    always_comb begin
        sum = SUMW'(p0_reg) + SUMW'(p1_reg) + SUMW'(p2_reg);
        mag = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
        rnd = {1'b0, mag} + ((SUMW+1)'(1) << (F-1));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n0_reg <= n0;
            n1_reg <= n1;
            n2_reg <= n2;
            u_reg  <= u_ext;
            v_reg  <= v_ext;
            w_reg  <= w_sat;
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            mag_o  <= rnd[F+MW-1:F];
            neg_o  <= sum[SUMW-1];
        end
    end
endmodule

FILE: rtl/core/bni_norm.sv
`timescale 1ns / 1ps
module bni_norm #(
    parameter int MW = 20,
    parameter int LW = 21
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic [bni_pkg::LANES-1:0][MW-1:0]      mag_i,
    input  logic [bni_pkg::LANES-1:0]              neg_i,
    output logic [bni_pkg::LANES-1:0][MW-1:0]      mag_o,
    output logic [bni_pkg::LANES-1:0]              neg_o,
    output logic [LW-1:0]                          len_o,
    output logic                                   zero_o
);
    localparam int RW = LW + 3;
    localparam int QW = 2 * LW;

    logic [bni_pkg::LANES-1:0][2*MW-1:0] sq_reg;
    logic [bni_pkg::LANES-1:0][MW-1:0]   md_reg [LW+2];
    logic [bni_pkg::LANES-1:0]           nd_reg [LW+2];
    logic                                zd_reg [LW+1];
    logic [RW-1:0]                       rem_reg  [LW+1];
    logic [LW-1:0]                       root_reg [LW+1];
    logic [QW-1:0]                       qsh_reg  [LW+1];
    logic [QW-1:0]                       q_next;

    // Merge the lanes into one sum of squares
    always_comb begin
        q_next = QW'(sq_reg[0]) + QW'(sq_reg[1]) + QW'(sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < bni_pkg::LANES; i++) begin
                sq_reg[i] <= mag_i[i] * mag_i[i];
            end
            md_reg[0]   <= mag_i;
            nd_reg[0]   <= neg_i;
            md_reg[1]   <= md_reg[0];
            nd_reg[1]   <= nd_reg[0];
            qsh_reg[0]  <= q_next;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            zd_reg[0]   <= (q_next == '0);
        end
    end

    // Floor square root, one root bit per stage
    for (genvar k = 0; k < LW; k++) begin : g_sqrt
        logic [RW-1:0] t;
        logic [RW-1:0] trial;
        logic          ge;
        always_comb begin
            t     = {rem_reg[k][RW-3:0], qsh_reg[k][QW-1:QW-2]};
            trial = RW'({root_reg[k], 2'b01});
            ge    = (t >= trial);
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= ge ? (t - trial) : t;
                root_reg[k+1] <= {root_reg[k][LW-2:0], ge};
                qsh_reg[k+1]  <= qsh_reg[k] << 2;
                zd_reg[k+1]   <= zd_reg[k];
                md_reg[k+2]   <= md_reg[k+1];
                nd_reg[k+2]   <= nd_reg[k+1];
            end
        end
    end

    assign len_o  = root_reg[LW];
    assign zero_o = zd_reg[LW];
    assign mag_o  = md_reg[LW+1];
    assign neg_o  = nd_reg[LW+1];
endmodule

FILE: rtl/core/bni_div_lane.sv
`timescale 1ns / 1ps
module bni_div_lane #(
    parameter int F  = 14,
    parameter int MW = 20,
    parameter int LW = 21
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [MW-1:0]                     mag,
    input  logic                              neg,
    input  logic                              zero,
    input  logic [LW-1:0]                     len,
    output logic signed [bni_pkg::UNIT_W-1:0] unit_o
);
    localparam int QB  = F + 2;
    localparam int NW  = MW + F + 1;
    localparam int EXW = (QB > bni_pkg::UNIT_W) ? QB : bni_pkg::UNIT_W;

    logic [NW-1:0] num;
    logic [LW-1:0] rem_in;

    logic [LW-1:0] rem_reg  [QB];
    logic [QB-1:0] quo_reg  [QB];
    logic [QB-1:0] nlo_reg  [QB];
    logic [LW-1:0] len_reg  [QB];
    logic          neg_reg  [QB];
    logic          zero_reg [QB];

    logic [QB-1:0]         one_q;
    logic [QB-1:0]         clamped;
    logic signed [QB-1:0]  sval;
    logic signed [EXW-1:0] sext;

    // Scale the component and add half the length for rounding
    always_comb begin
        num    = (NW'(mag) << F) + NW'(len >> 1);
        rem_in = LW'(num[NW-1:QB]);
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [LW-1:0] rem_p, len_p;
        logic [QB-1:0] quo_p, nlo_p;
        logic          neg_p, zero_p;
        logic [LW:0]   t;
        logic          ge;
        if (k == 0) begin : g_first
            always_comb begin
                rem_p  = rem_in;
                quo_p  = '0;
                nlo_p  = num[QB-1:0];
                len_p  = len;
                neg_p  = neg;
                zero_p = zero;
            end
        end else begin : g_next
            always_comb begin
                rem_p  = rem_reg[k-1];
                quo_p  = quo_reg[k-1];
                nlo_p  = nlo_reg[k-1];
                len_p  = len_reg[k-1];
                neg_p  = neg_reg[k-1];
                zero_p = zero_reg[k-1];
            end
        end
        always_comb begin
            t  = {rem_p, nlo_p[QB-1]};
            ge = (t >= {1'b0, len_p});
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? LW'(t - {1'b0, len_p}) : t[LW-1:0];
                quo_reg[k]  <= {quo_p[QB-2:0], ge};
                nlo_reg[k]  <= nlo_p << 1;
                len_reg[k]  <= len_p;
                neg_reg[k]  <= neg_p;
                zero_reg[k] <= zero_p;
            end
        end
    end

    // Clamp to one, apply sign, drop on zero length
    always_comb begin
        one_q   = QB'(1) << F;
        clamped = (quo_reg[QB-1] > one_q) ? one_q : quo_reg[QB-1];
        sval    = neg_reg[QB-1] ? $signed(-clamped) : $signed(clamped);
        sext    = EXW'(sval);
        if (zero_reg[QB-1]) begin
            sext = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            unit_o <= sext[bni_pkg::UNIT_W-1:0];
        end
    end
endmodule

FILE: rtl/core/barycentric_normal_interpolator_unit.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    three vertex normals, u and v weights
// m_       out        m_valid/m_ready    unit normal x/y/z, zero_length flag
//
// One request enters per cycle while no result is held; every stage advances together.
// The pipeline depth is set by the root-bit stages of the square root and the
// quotient-bit divider stages, and grows with FRACTION_BITS above 14.
// aresetn clears the valid bits only; datapath registers are not reset.
// A held result stalls the whole pipeline; s_ready follows !m_valid || m_ready.
`timescale 1ns / 1ps
`include "barycentric_normal_interpolator_unit_defines.svh"
module barycentric_normal_interpolator_unit #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [bni_pkg::NORMAL_W-1:0] s_first_normal_x,
    input  logic signed [bni_pkg::NORMAL_W-1:0] s_first_normal_y,
    input  logic signed [bni_pkg::NORMAL_W-1:0] s_first_normal_z,
    input  logic signed [bni_pkg::NORMAL_W-1:0] s_second_normal_x,
    input  logic signed [bni_pkg::NORMAL_W-1:0] s_second_normal_y,
    input  logic signed [bni_pkg::NORMAL_W-1:0] s_second_normal_z,
    input  logic signed [bni_pkg::NORMAL_W-1:0] s_third_normal_x,
    input  logic signed [bni_pkg::NORMAL_W-1:0] s_third_normal_y,
    input  logic signed [bni_pkg::NORMAL_W-1:0] s_third_normal_z,
    input  logic        [bni_pkg::WEIGHT_W-1:0] s_u_weight,
    input  logic        [bni_pkg::WEIGHT_W-1:0] s_v_weight,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bni_pkg::UNIT_W-1:0]   m_unit_x,
    output logic signed [bni_pkg::UNIT_W-1:0]   m_unit_y,
    output logic signed [bni_pkg::UNIT_W-1:0]   m_unit_z,
    output logic                                m_zero_length
);
    localparam int F     = FRACTION_BITS;
    localparam int WB    = (F + 1 > bni_pkg::WEIGHT_W) ? F + 1 : bni_pkg::WEIGHT_W;
    localparam int MW    = bni_pkg::NORMAL_W + WB + 3 - F;
    localparam int LW    = MW + 1;
    localparam int QB    = F + 2;
    localparam int DEPTH = 3 + LW + 2 + QB + 1;

    logic en;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    logic signed [bni_pkg::NORMAL_W-1:0] n0 [bni_pkg::LANES];
    logic signed [bni_pkg::NORMAL_W-1:0] n1 [bni_pkg::LANES];
    logic signed [bni_pkg::NORMAL_W-1:0] n2 [bni_pkg::LANES];

    logic [bni_pkg::LANES-1:0][MW-1:0] lane_mag, norm_mag;
    logic [bni_pkg::LANES-1:0]         lane_neg, norm_neg;
    logic [LW-1:0]                     len;
    logic                              zero;
    logic                              zero_reg [QB+1];
    logic signed [bni_pkg::UNIT_W-1:0] unit [bni_pkg::LANES];

    // Advance everything unless a result is held
    assign en      = !valid_reg[DEPTH-1] || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg[DEPTH-1];

    always_comb begin
        valid_next = {valid_reg[DEPTH-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        n0[0] = s_first_normal_x;  n0[1] = s_first_normal_y;  n0[2] = s_first_normal_z;
        n1[0] = s_second_normal_x; n1[1] = s_second_normal_y; n1[2] = s_second_normal_z;
        n2[0] = s_third_normal_x;  n2[1] = s_third_normal_y;  n2[2] = s_third_normal_z;
    end

    // Weighted sum, one lane per component
    for (genvar i = 0; i < bni_pkg::LANES; i++) begin : g_sum
        bni_sum_lane #(.F(F), .WB(WB), .MW(MW)) u_sum (
            .aclk  (aclk),
            .en    (en),
            .n0    (n0[i]),
            .n1    (n1[i]),
            .n2    (n2[i]),
            .u     (s_u_weight),
            .v     (s_v_weight),
            .mag_o (lane_mag[i]),
            .neg_o (lane_neg[i])
        );
    end

    // Merge lanes into the length
    bni_norm #(.MW(MW), .LW(LW)) u_norm (
        .aclk   (aclk),
        .en     (en),
        .mag_i  (lane_mag),
        .neg_i  (lane_neg),
        .mag_o  (norm_mag),
        .neg_o  (norm_neg),
        .len_o  (len),
        .zero_o (zero)
    );

    // Divide each component by the length
    for (genvar i = 0; i < bni_pkg::LANES; i++) begin : g_div
        bni_div_lane #(.F(F), .MW(MW), .LW(LW)) u_div (
            .aclk   (aclk),
            .en     (en),
            .mag    (norm_mag[i]),
            .neg    (norm_neg[i]),
            .zero   (zero),
            .len    (len),
            .unit_o (unit[i])
        );
    end

    // Delay the zero flag alongside the divider
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= zero;
            for (int k = 1; k <= QB; k++) begin
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    assign m_unit_x      = unit[0];
    assign m_unit_y      = unit[1];
    assign m_unit_z      = unit[2];
    assign m_zero_length = zero_reg[QB];

    `BNI_ASSERT_IMPL(a_zero_gives_zeros, aclk, aresetn, m_valid && m_zero_length, m_unit_x == '0 && m_unit_y == '0 && m_unit_z == '0, "zero length result with nonzero components")
    `BNI_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, valid_reg[0], "accepted request did not enter the pipeline")
    `BNI_ASSERT_NEXT(a_stall_holds, aclk, aresetn, !s_ready, $stable(valid_reg), "pipeline moved while stalled")
endmodule
